### rtl/box_filter_convolution_assert.svh
`ifndef BOX_FILTER_CONVOLUTION_ASSERT_SVH
`define BOX_FILTER_CONVOLUTION_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BFC_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BFC_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bfc_pkg.sv
package bfc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WLEN_W   = 7;
	localparam int CFG_W    = 16;
	localparam int SCALE_W  = 16;

	localparam logic              REG_WINDOW_LENGTH = 1'b0;
	localparam logic              REG_SCALE         = 1'b1;
	localparam logic [WLEN_W-1:0] WLEN_RESET        = 7'd1;
	localparam logic [SCALE_W-1:0] SCALE_RESET      = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_EMIT
	} bfc_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} bfc_mem_ctrl_t;

endpackage

### rtl/box_filter_convolution.sv
// Box filter: each accepted sample yields scale times the sum of itself and the
// previous L-1 samples (L = window_length, 0 read as 1, clamped to MAX_WINDOW);
// after a sample with last_in the block emits L-1 more results as zeros shift
// in, marks the final one with last_out, and clears the window. A sample is
// taken only while the block is idle. The memory read happens in the accept
// cycle, then the block steps through sum update and write-back, multiply and
// output load; each drain result passes through the same steps. The
// read-modify-write through the window memory and the registered multiplier
// set these steps. A stalled output holds the block in its output step.
// Writing window_length clears the window at once, no clearing pass is needed.
module box_filter_convolution #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bfc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bfc_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfc_pkg::SAMPLE_W-1:0]  filtered,
	output logic                          last_out
);
	import bfc_pkg::*;

`include "box_filter_convolution_assert.svh"

	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int SUM_W  = SAMPLE_W + ADDR_W;

	bfc_state_t          state_q, state_d;
	logic [WLEN_W-1:0]   wlen_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [LEN_W-1:0]    len;
	logic [ADDR_W-1:0]   wp_q;
	logic [SUM_W-1:0]    sum_q;
	logic [ADDR_W-1:0]   drain_rem_q;
	logic                final_q;
	logic [SAMPLE_W-1:0] cur_sample_q;
	logic [IDX_W-1:0]    old_raw;
	logic [ADDR_W-1:0]   old_idx;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] scaled;
	logic                rd_en, wr_en, mul_en, emit, cfg_wlen, clr;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] filtered_q;
	logic                last_out_q;
	bfc_mem_ctrl_t       mem_ctrl;

	// tap count
	always_comb begin
		if (wlen_q == '0) begin
			len = LEN_W'(1);
		end else if (wlen_q > WLEN_W'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wlen_q);
		end
	end

	// slot of the sample leaving the window
	assign old_raw = {1'b0, wp_q} + IDX_W'(MAX_WINDOW) - IDX_W'(len);
	assign old_idx = (old_raw >= IDX_W'(MAX_WINDOW)) ? ADDR_W'(old_raw - IDX_W'(MAX_WINDOW))
	                                                 : ADDR_W'(old_raw);

	assign cfg_wlen = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
	assign clr      = cfg_wlen || (emit && final_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		mul_en   = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					rd_en   = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				wr_en   = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit = 1'b1;
					if (drain_rem_q != '0) begin
						rd_en   = 1'b1;
						state_d = ST_ACC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: wlen_q  <= cfg_data[WLEN_W-1:0];
				REG_SCALE:         scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			sum_q       <= '0;
			drain_rem_q <= '0;
			final_q     <= 1'b0;
		end else if (clr) begin
			wp_q        <= '0;
			sum_q       <= '0;
			drain_rem_q <= '0;
			final_q     <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				drain_rem_q <= last_in ? ADDR_W'(len - LEN_W'(1)) : '0;
				final_q     <= last_in && (len == LEN_W'(1));
			end else if (emit && drain_rem_q != '0) begin
				drain_rem_q <= drain_rem_q - ADDR_W'(1);
				final_q     <= (drain_rem_q == ADDR_W'(1));
			end
			if (wr_en) begin
				sum_q <= sum_q + SUM_W'(cur_sample_q) - SUM_W'(rd_data);
				wp_q  <= (wp_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + ADDR_W'(1);
			end
		end
	end

	// payload of the push in flight; drain pushes shift in zeros
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cur_sample_q <= sample;
		end else if (emit) begin
			cur_sample_q <= '0;
		end
	end

	assign mem_ctrl.rd_en = rd_en;
	assign mem_ctrl.wr_en = wr_en;
	assign mem_ctrl.clr   = clr;

	bfc_window_mem #(
		.DEPTH (MAX_WINDOW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.rd_addr (old_idx),
		.wr_addr (wp_q),
		.wr_data (cur_sample_q),
		.rd_data (rd_data)
	);

	bfc_scale #(
		.SUM_W (SUM_W)
	) u_scale (
		.clk    (clk),
		.en     (mul_en),
		.sum    (sum_q),
		.scale  (scale_q),
		.result (scaled)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			filtered_q <= scaled;
			last_out_q <= final_q;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign last_out  = last_out_q;

	`BFC_CHECK(a_no_rd_wr_same_cycle, rd_en, !wr_en, "window read and write collide")
	`BFC_CHECK(a_final_ends_drain, emit && final_q, drain_rem_q == '0, "last_out before drain end")
	`BFC_CHECK_NEXT(a_clear_after_final, emit && final_q && !cfg_wlen,
		(sum_q == '0) && (wp_q == '0) && (state_q == ST_IDLE), "window not cleared after signal")
	`BFC_CHECK(a_acc_after_read, state_q == ST_ACC, $past(rd_en), "sum update without memory read")

endmodule

### rtl/bfc_window_mem.sv
module bfc_window_mem #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfc_pkg::bfc_mem_ctrl_t        ctrl,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [bfc_pkg::SAMPLE_W-1:0]  wr_data,
	output logic [bfc_pkg::SAMPLE_W-1:0]  rd_data
);
	import bfc_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [SAMPLE_W-1:0] data_q;
	logic                rd_vld_q;

	// entries that are not valid read as zero
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				vld_q <= '0;
			end else if (ctrl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? data_q : '0;

endmodule

### rtl/bfc_scale.sv
module bfc_scale #(
	parameter int SUM_W = 22
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [SUM_W-1:0]             sum,
	input  logic [bfc_pkg::SCALE_W-1:0]  scale,
	output logic [bfc_pkg::SAMPLE_W-1:0] result
);
	import bfc_pkg::*;

	localparam int PROD_W = SUM_W + SCALE_W;

	logic [PROD_W-1:0]   prod_s1;
	logic [SUM_W-1:0]    shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(sum) * PROD_W'(scale);
		end
	end

	// drop the Q0.16 fraction, clamp at full scale
	assign shifted = prod_s1[PROD_W-1:SCALE_W];
	assign result  = (shifted > SUM_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}}
	                                                      : shifted[SAMPLE_W-1:0];

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_MAX = 64;
	localparam int LIMIT   = 2_000_000;

	typedef struct {
		logic [15:0] filtered;
		logic        last;
	} result_t;

	// Mirrors the block: running window sum over the last L samples, scaled and saturated.
	class filter_scoreboard;
		logic [15:0] window [WIN_MAX];
		logic [21:0] total;
		logic [5:0]  wp;
		logic [6:0]  wlen;
		logic [15:0] gain;
		result_t     awaited [$];
		int          errors;

		function new();
			clear_window();
			wlen   = bfc_pkg::WLEN_RESET;
			gain   = bfc_pkg::SCALE_RESET;
			errors = 0;
		endfunction

		function void clear_window();
			foreach (window[i])
				window[i] = '0;
			total = '0;
			wp    = '0;
		endfunction

		function void write_reg(logic idx, logic [15:0] data);
			if (idx == bfc_pkg::REG_WINDOW_LENGTH) begin
				wlen = data[6:0];
				clear_window();
			end else begin
				gain = data;
			end
		endfunction

		function int taps();
			if (wlen == 0)
				return 1;
			if (wlen > WIN_MAX)
				return WIN_MAX;
			return wlen;
		endfunction

		function logic [15:0] push(logic [15:0] s, int len);
			logic [5:0]  oldest_slot;
			logic [37:0] prod;
			oldest_slot = wp - 6'(len);
			total = total + 22'(s) - 22'(window[oldest_slot]);
			window[wp] = s;
			wp = wp + 6'd1;
			prod = gain * total;
			if (prod[37:16] > 22'h00FFFF)
				return 16'hFFFF;
			return prod[31:16];
		endfunction

		function void note_sample(logic [15:0] s, logic last);
			int len;
			result_t r;
			len = taps();
			r.filtered = push(s, len);
			r.last = last && (len == 1);
			awaited = {awaited, r};
			if (last) begin
				for (int d = 1; d < len; d++) begin
					r.filtered = push(16'h0000, len);
					r.last = (d == len - 1);
					awaited = {awaited, r};
				end
				clear_window();
			end
		endfunction

		function void check_result(logic [15:0] f, logic l);
			result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected beat: filtered=%h last_out=%b", f, l);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (f !== want.filtered) begin
				$error("filtered: expected %h, got %h", want.filtered, f);
				errors++;
			end
			if (l !== want.last) begin
				$error("last_out: expected %b, got %b", want.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				$error("%0d expected beats never arrived", awaited.size());
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] sample;
	logic        last_in;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] filtered;
	logic        last_out;

	filter_scoreboard sb = new();
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	bit long_hold = 1'b0;
	int cycles = 0;

	box_filter_convolution #(
		.MAX_WINDOW(WIN_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.last_out(last_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_sample(sample, last_in);
			if (out_valid && !out_stall)
				sb.check_result(filtered, last_out);
		end
	end

	// receive side
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				n = recv_gaps ? $urandom_range(0, 19) : 0;
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_beat(input logic [15:0] s, input logic l);
		int gap;
		gap = send_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last_in  <= l;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic quiesce(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg_port(input logic idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] wl, input logic [15:0] sc);
		quiesce(8);
		write_reg_port(bfc_pkg::REG_WINDOW_LENGTH, wl);
		write_reg_port(bfc_pkg::REG_SCALE, sc);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// upper bits random too; the block keeps only the low seven
	function automatic logic [15:0] pick_length();
		logic [6:0] low;
		case ($urandom_range(0, 7))
			0: low = 7'd0;
			1: low = 7'd1;
			2: low = 7'd2;
			3: low = 7'd64;
			4: low = 7'($urandom_range(65, 127));
			default: low = 7'($urandom_range(1, 12));
		endcase
		return {9'($urandom_range(0, 511)), low};
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// mostly whole signals ending in last_in, a few cut short
	task automatic run_signals(input int items, input int max_len);
		int left, sig_len;
		bit cut;
		left = items;
		while (left > 0) begin
			sig_len = $urandom_range(1, max_len);
			cut = ($urandom_range(0, 9) == 0);
			for (int k = 0; k < sig_len && left > 0; k++) begin
				send_beat(rand_sample(), (k == sig_len - 1) && !cut);
				left--;
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= bfc_pkg::REG_WINDOW_LENGTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample    <= '0;
		last_in   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one tap, full scale
		send_beat(16'h0000, 1'b0);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'h8000, 1'b1);

		set_config(16'h0003, 16'hFFFF);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'h1234, 1'b1);
		send_beat(16'hFFFF, 1'b1);

		// length zero reads as one tap
		set_config(16'hFF80, 16'h0000);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'hFFFF, 1'b1);

		// length above the maximum clamps
		set_config(16'hA5E4, 16'h8000);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'h0007, 1'b1);

		set_config(16'h807F, 16'h0001);
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'hFFFF, 1'b1);

		set_config(16'h0040, 16'hFFFF);
		send_beat(16'hFFFF, 1'b1);

		// length write in the middle of a signal restarts the window
		set_config(16'h0004, 16'h4000);
		send_beat(16'hAAAA, 1'b0);
		quiesce(8);
		write_reg_port(bfc_pkg::REG_WINDOW_LENGTH, 16'h0002);
		send_beat(16'h5555, 1'b1);

		for (int p = 0; p < 6; p++) begin
			set_config(pick_length(), pick_scale());
			send_gaps = (p != 2);
			recv_gaps = (p != 2);
			if (p == 3) begin
				send_gaps = 1'b0;
				long_hold = 1'b1;
			end
			if (p == 4) begin
				run_signals(11, 10);
				quiesce(0);
				run_signals(11, 10);
			end else begin
				run_signals(22, 10);
			end
		end

		quiesce(20);
		sb.close_out();
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
